FILE: hw/rtl/afa_pkg.sv
// afa_pkg: item types, register indexes and sequencer states for the
// attractor force accumulate core. No dependencies.
package afa_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATT_BASE = 3'd1;

  localparam int unsigned DIV_STEPS = 32;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [31:0] acc_in_x;
    logic signed [31:0] acc_in_y;
    logic signed [31:0] acc_in_z;
    logic               last_particle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] acc_out_x;
    logic signed [31:0] acc_out_y;
    logic signed [31:0] acc_out_z;
    logic               last_done;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_CHK,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_DONE
  } state_e;

endpackage

FILE: hw/rtl/attractor_force_accumulate_core.sv
// attractor_force_accumulate_core: adds point attractor pulls to one particle.
// Uses afa_pkg for item types, register indexes and states.
// No attractors: IDLE goes to DONE. Else each attractor in use runs LOAD, SQ,
// CHK; then per axis MUL, DIV (32-step shared divider), ACC if d2 is nonzero.
// One item at a time: busy stays high from accept until the result strobe.
// The result is shown on result_o with done_o, high for one cycle; no stall.
// Reset (async, active low) clears count, attractors and sequencer.
module attractor_force_accumulate_core #(
  parameter int unsigned MAX_ATTRACTORS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  afa_pkg::in_item_t                   item_i,
  output logic                                done_o,
  output afa_pkg::out_item_t                  result_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [afa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [afa_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  localparam int unsigned AW = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
  localparam logic [2:0] MaxCnt = 3'(MAX_ATTRACTORS);

  afa_pkg::state_e state_q, state_d;

  logic [2:0]          count_q;
  logic [63:0]         att_q [MAX_ATTRACTORS];
  logic [2:0]          n_eff;
  logic [2:0]          wr_slot;

  logic signed [15:0]  pos_q [3];
  logic signed [31:0]  acc_q [3];
  logic                last_q;
  logic signed [16:0]  off_q [3];
  logic [15:0]         wm_q;
  logic                wneg_q;
  logic [AW-1:0]       att_idx_q;
  logic [1:0]          comp_q;
  logic [4:0]          step_q;
  logic [33:0]         d2_q;
  logic [33:0]         rem_q;
  logic [31:0]         quo_q;
  logic                done_q;
  afa_pkg::out_item_t  res_q;

  logic [63:0]         att_sel;
  logic [15:0]         off_mag;
  logic [15:0]         mul_b;
  logic [31:0]         prod;
  logic [34:0]         rem_sh;
  logic [35:0]         rem_diff;
  logic                q_bit;
  logic signed [32:0]  term;
  logic signed [33:0]  sum;
  logic signed [31:0]  sat;
  logic                last_att;
  logic                last_comp;
  logic                step_end;

  assign n_eff   = (count_q > MaxCnt) ? MaxCnt : count_q;
  assign wr_slot = cfg_index_i - afa_pkg::CFG_ATT_BASE;
  assign att_sel = att_q[att_idx_q];

  assign off_mag = off_q[comp_q][16] ? 16'(-off_q[comp_q]) : off_q[comp_q][15:0];
  assign mul_b   = (state_q == afa_pkg::ST_SQ) ? off_mag : wm_q;
  assign prod    = off_mag * mul_b;

  assign rem_sh   = {rem_q, quo_q[31]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, d2_q};
  assign q_bit    = ~rem_diff[35];

  assign term = (off_q[comp_q][16] ^ wneg_q) ? -$signed({1'b0, quo_q})
                                             : $signed({1'b0, quo_q});
  assign sum  = 34'(acc_q[comp_q]) + 34'(term);
  always_comb begin
    if (sum > 34'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -34'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
  end

  assign last_att  = ({{(3 - AW){1'b0}}, att_idx_q} == 3'(n_eff - 3'd1));
  assign last_comp = (comp_q == 2'd2);
  assign step_end  = (step_q == 5'(afa_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      afa_pkg::ST_IDLE: begin
        if (start) begin
          state_d = (n_eff == 3'd0) ? afa_pkg::ST_DONE : afa_pkg::ST_LOAD;
        end
      end
      afa_pkg::ST_LOAD: state_d = afa_pkg::ST_SQ;
      afa_pkg::ST_SQ: begin
        if (last_comp) state_d = afa_pkg::ST_CHK;
      end
      afa_pkg::ST_CHK: begin
        if (d2_q != 34'd0) begin
          state_d = afa_pkg::ST_MUL;
        end else begin
          state_d = last_att ? afa_pkg::ST_DONE : afa_pkg::ST_LOAD;
        end
      end
      afa_pkg::ST_MUL: state_d = afa_pkg::ST_DIV;
      afa_pkg::ST_DIV: begin
        if (step_end) state_d = afa_pkg::ST_ACC;
      end
      afa_pkg::ST_ACC: begin
        if (!last_comp) begin
          state_d = afa_pkg::ST_MUL;
        end else begin
          state_d = last_att ? afa_pkg::ST_DONE : afa_pkg::ST_LOAD;
        end
      end
      afa_pkg::ST_DONE: state_d = afa_pkg::ST_IDLE;
      default: state_d = afa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy        = (state_q != afa_pkg::ST_IDLE);
    cfg_ready_o = 1'b1;
    done_o      = done_q;
    result_o    = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= afa_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == afa_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      for (int i = 0; i < MAX_ATTRACTORS; i++) att_q[i] <= 64'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == afa_pkg::CFG_COUNT) begin
        count_q <= cfg_data_i[2:0];
      end else if (cfg_index_i <= 3'(MAX_ATTRACTORS)) begin
        att_q[wr_slot[AW-1:0]] <= cfg_data_i;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      afa_pkg::ST_IDLE: begin
        pos_q[0]  <= item_i.pos_x;
        pos_q[1]  <= item_i.pos_y;
        pos_q[2]  <= item_i.pos_z;
        acc_q[0]  <= item_i.acc_in_x;
        acc_q[1]  <= item_i.acc_in_y;
        acc_q[2]  <= item_i.acc_in_z;
        last_q    <= item_i.last_particle;
        att_idx_q <= '0;
      end
      afa_pkg::ST_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          off_q[c] <= 17'($signed(att_sel[16*c +: 16])) - 17'(pos_q[c]);
        end
        wneg_q <= att_sel[63];
        wm_q   <= att_sel[63] ? 16'(-att_sel[63:48]) : att_sel[63:48];
        comp_q <= 2'd0;
        d2_q   <= 34'd0;
      end
      afa_pkg::ST_SQ: begin
        d2_q   <= d2_q + 34'(prod);
        comp_q <= last_comp ? 2'd0 : comp_q + 2'd1;
      end
      afa_pkg::ST_CHK: begin
        if (d2_q == 34'd0) att_idx_q <= att_idx_q + AW'(1);
      end
      afa_pkg::ST_MUL: begin
        rem_q  <= {18'd0, prod[31:16]};
        quo_q  <= {prod[15:0], 16'd0};
        step_q <= 5'd0;
      end
      afa_pkg::ST_DIV: begin
        rem_q  <= q_bit ? rem_diff[33:0] : rem_sh[33:0];
        quo_q  <= {quo_q[30:0], q_bit};
        step_q <= step_q + 5'd1;
      end
      afa_pkg::ST_ACC: begin
        acc_q[comp_q] <= sat;
        if (last_comp) begin
          comp_q    <= 2'd0;
          att_idx_q <= att_idx_q + AW'(1);
        end else begin
          comp_q <= comp_q + 2'd1;
        end
      end
      afa_pkg::ST_DONE: begin
        res_q.acc_out_x <= acc_q[0];
        res_q.acc_out_y <= acc_q[1];
        res_q.acc_out_z <= acc_q[2];
        res_q.last_done <= last_q;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/afa_checker.sv
// afa_checker: port-level checks of the command handshake of the core.
// Uses afa_pkg for the item types; bound to attractor_force_accumulate_core.
module afa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input afa_pkg::out_item_t result_o
);

  ap_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  ap_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped without a result");

  ap_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(result_o)) else $error("result unknown at strobe");

endmodule

bind attractor_force_accumulate_core afa_checker u_afa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
